/* rtl/rti_pkg.sv */
package rti_pkg;

    localparam int COORD_WIDTH = 21;
    localparam int FIELD_W     = 63;
    localparam int DW          = COORD_WIDTH + 1;   // coordinate difference
    localparam int PW          = 2 * DW + 1;        // cross product term
    localparam int MW          = DW + PW;           // dot product partial
    localparam int SW          = MW + 2;            // dot product sum
    localparam int THR_W       = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd1074;
    localparam int IN_TDATA_W  = 320;
    localparam int OUT_TDATA_W = 8;
    localparam int OUTCOME_W   = 3;
    localparam int NPROD       = 12;

    localparam logic [OUTCOME_W-1:0] OC_HIT      = 3'd0;
    localparam logic [OUTCOME_W-1:0] OC_PARALLEL = 3'd1;
    localparam logic [OUTCOME_W-1:0] OC_U_OUT    = 3'd2;
    localparam logic [OUTCOME_W-1:0] OC_V_OUT    = 3'd3;
    localparam logic [OUTCOME_W-1:0] OC_T_OUT    = 3'd4;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
    } pvec_t;

    typedef struct packed {
        dvec_t dir;
        dvec_t e1;
        dvec_t e2;
        dvec_t s;
        logic  seg;
    } geo_t;

    typedef struct packed {
        dvec_t dir;
        dvec_t e1;
        dvec_t e2;
        dvec_t s;
        pvec_t p;
        pvec_t q;
        logic  seg;
    } xgeo_t;

    typedef struct packed {
        logic signed [SW-1:0] det;
        logic signed [SW-1:0] u;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] t;
        logic                 seg;
    } sums_t;

    function automatic logic signed [DW-1:0] coord(input logic [FIELD_W-1:0] f, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = $signed(f[k*COORD_WIDTH +: COORD_WIDTH]);
        return DW'(c);
    endfunction

    function automatic dvec_t vsub(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
        dvec_t r;
        r.x = coord(a, 0) - coord(b, 0);
        r.y = coord(a, 1) - coord(b, 1);
        r.z = coord(a, 2) - coord(b, 2);
        return r;
    endfunction

    function automatic dvec_t vext(input logic [FIELD_W-1:0] a);
        dvec_t r;
        r.x = coord(a, 0);
        r.y = coord(a, 1);
        r.z = coord(a, 2);
        return r;
    endfunction

endpackage

/* rtl/rti_diff.sv */
module rti_diff (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rti_pkg::FIELD_W-1:0] org,
    input  logic [rti_pkg::FIELD_W-1:0] sec,
    input  logic [rti_pkg::FIELD_W-1:0] va,
    input  logic [rti_pkg::FIELD_W-1:0] vb,
    input  logic [rti_pkg::FIELD_W-1:0] vc,
    input  logic                      seg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rti_pkg::geo_t             out_geo
);

    logic          valid_reg;
    rti_pkg::geo_t geo_reg;
    rti_pkg::geo_t geo_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_geo   = geo_reg;

    always_comb
    begin
        geo_next.dir = seg ? rti_pkg::vsub(sec, org) : rti_pkg::vext(sec);
        geo_next.e1  = rti_pkg::vsub(vb, va);
        geo_next.e2  = rti_pkg::vsub(vc, va);
        geo_next.s   = rti_pkg::vsub(org, va);
        geo_next.seg = seg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            geo_reg <= geo_next;
        end
    end

endmodule

/* rtl/rti_cross.sv */
module rti_cross (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rti_pkg::geo_t  in_geo,
    output logic           out_valid,
    input  logic           out_ready,
    output rti_pkg::xgeo_t out_geo
);

    localparam int PRW = 2 * rti_pkg::DW;

    // stage a: the twelve cross-product terms
    logic                  a_valid_reg;
    rti_pkg::geo_t         a_geo_reg;
    logic signed [PRW-1:0] pp_reg  [rti_pkg::NPROD];
    logic signed [PRW-1:0] pp_next [rti_pkg::NPROD];
    // stage b: p = dir x e2, q = s x e1
    logic                  b_valid_reg;
    rti_pkg::xgeo_t        b_geo_reg;
    rti_pkg::xgeo_t        b_geo_next;
    logic                  a_ready;
    logic                  b_ready;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_geo   = b_geo_reg;

    always_comb
    begin
        pp_next[0]  = in_geo.dir.y * in_geo.e2.z;
        pp_next[1]  = in_geo.dir.z * in_geo.e2.y;
        pp_next[2]  = in_geo.dir.z * in_geo.e2.x;
        pp_next[3]  = in_geo.dir.x * in_geo.e2.z;
        pp_next[4]  = in_geo.dir.x * in_geo.e2.y;
        pp_next[5]  = in_geo.dir.y * in_geo.e2.x;
        pp_next[6]  = in_geo.s.y * in_geo.e1.z;
        pp_next[7]  = in_geo.s.z * in_geo.e1.y;
        pp_next[8]  = in_geo.s.z * in_geo.e1.x;
        pp_next[9]  = in_geo.s.x * in_geo.e1.z;
        pp_next[10] = in_geo.s.x * in_geo.e1.y;
        pp_next[11] = in_geo.s.y * in_geo.e1.x;
    end

    always_comb
    begin
        b_geo_next.dir = a_geo_reg.dir;
        b_geo_next.e1  = a_geo_reg.e1;
        b_geo_next.e2  = a_geo_reg.e2;
        b_geo_next.s   = a_geo_reg.s;
        b_geo_next.seg = a_geo_reg.seg;
        b_geo_next.p.x = rti_pkg::PW'(pp_reg[0])  - rti_pkg::PW'(pp_reg[1]);
        b_geo_next.p.y = rti_pkg::PW'(pp_reg[2])  - rti_pkg::PW'(pp_reg[3]);
        b_geo_next.p.z = rti_pkg::PW'(pp_reg[4])  - rti_pkg::PW'(pp_reg[5]);
        b_geo_next.q.x = rti_pkg::PW'(pp_reg[6])  - rti_pkg::PW'(pp_reg[7]);
        b_geo_next.q.y = rti_pkg::PW'(pp_reg[8])  - rti_pkg::PW'(pp_reg[9]);
        b_geo_next.q.z = rti_pkg::PW'(pp_reg[10]) - rti_pkg::PW'(pp_reg[11]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_geo_reg <= in_geo;
            pp_reg    <= pp_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_geo_reg <= b_geo_next;
        end
    end

endmodule

/* rtl/rti_dot.sv */
module rti_dot (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rti_pkg::xgeo_t in_geo,
    output logic           out_valid,
    input  logic           out_ready,
    output rti_pkg::sums_t out_sums
);

    localparam int MW = rti_pkg::MW;
    localparam int SW = rti_pkg::SW;

    // stage a: partial products of det, U, V, T (three each)
    logic                 a_valid_reg;
    logic                 a_seg_reg;
    logic signed [MW-1:0] mp_reg  [rti_pkg::NPROD];
    logic signed [MW-1:0] mp_next [rti_pkg::NPROD];
    // stage b: the sums
    logic                 b_valid_reg;
    rti_pkg::sums_t       b_sums_reg;
    rti_pkg::sums_t       b_sums_next;
    logic                 a_ready;
    logic                 b_ready;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_sums  = b_sums_reg;

    always_comb
    begin
        mp_next[0]  = in_geo.e1.x * in_geo.p.x;
        mp_next[1]  = in_geo.e1.y * in_geo.p.y;
        mp_next[2]  = in_geo.e1.z * in_geo.p.z;
        mp_next[3]  = in_geo.s.x * in_geo.p.x;
        mp_next[4]  = in_geo.s.y * in_geo.p.y;
        mp_next[5]  = in_geo.s.z * in_geo.p.z;
        mp_next[6]  = in_geo.dir.x * in_geo.q.x;
        mp_next[7]  = in_geo.dir.y * in_geo.q.y;
        mp_next[8]  = in_geo.dir.z * in_geo.q.z;
        mp_next[9]  = in_geo.e2.x * in_geo.q.x;
        mp_next[10] = in_geo.e2.y * in_geo.q.y;
        mp_next[11] = in_geo.e2.z * in_geo.q.z;
    end

    always_comb
    begin
        b_sums_next.det = SW'(mp_reg[0]) + SW'(mp_reg[1]) + SW'(mp_reg[2]);
        b_sums_next.u   = SW'(mp_reg[3]) + SW'(mp_reg[4]) + SW'(mp_reg[5]);
        b_sums_next.v   = SW'(mp_reg[6]) + SW'(mp_reg[7]) + SW'(mp_reg[8]);
        b_sums_next.t   = SW'(mp_reg[9]) + SW'(mp_reg[10]) + SW'(mp_reg[11]);
        b_sums_next.seg = a_seg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            mp_reg    <= mp_next;
            a_seg_reg <= in_geo.seg;
        end
        if (b_ready && a_valid_reg)
        begin
            b_sums_reg <= b_sums_next;
        end
    end

endmodule

/* rtl/rti_decide.sv */
module rti_decide (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rti_pkg::sums_t                  in_sums,
    input  logic [rti_pkg::THR_W-1:0]       det_threshold,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_hit,
    output logic [rti_pkg::OUTCOME_W-1:0]   out_outcome
);

    localparam int SW = rti_pkg::SW;

    // stage a: sign correction and the near-parallel test
    logic                 a_valid_reg;
    logic                 a_par_reg;
    logic                 a_seg_reg;
    logic signed [SW-1:0] adet_reg;
    logic signed [SW-1:0] u_reg;
    logic signed [SW-1:0] v_reg;
    logic signed [SW-1:0] t_reg;
    logic                 flip;
    logic signed [SW-1:0] adet_next;
    logic signed [SW-1:0] thr_ext;
    // stage b: range checks, first failure wins
    logic                            b_valid_reg;
    logic                            hit_reg;
    logic [rti_pkg::OUTCOME_W-1:0]   outcome_reg;
    logic [rti_pkg::OUTCOME_W-1:0]   outcome_next;
    logic signed [SW:0]              uv_sum;
    logic                            a_ready;
    logic                            b_ready;

    assign b_ready     = !b_valid_reg || out_ready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign in_ready    = a_ready;
    assign out_valid   = b_valid_reg;
    assign out_hit     = hit_reg;
    assign out_outcome = outcome_reg;

    assign flip      = in_sums.det[SW-1];
    assign adet_next = flip ? -in_sums.det : in_sums.det;
    assign thr_ext   = $signed(SW'(det_threshold));
    assign uv_sum    = (SW+1)'(u_reg) + (SW+1)'(v_reg);

    always_comb
    begin
        priority if (a_par_reg)
        begin
            outcome_next = rti_pkg::OC_PARALLEL;
        end
        else if (u_reg < 0 || adet_reg < u_reg)
        begin
            outcome_next = rti_pkg::OC_U_OUT;
        end
        else if (v_reg < 0 || (SW+1)'(adet_reg) < uv_sum)
        begin
            outcome_next = rti_pkg::OC_V_OUT;
        end
        else if (t_reg <= 0 || (a_seg_reg && t_reg >= adet_reg))
        begin
            outcome_next = rti_pkg::OC_T_OUT;
        end
        else
        begin
            outcome_next = rti_pkg::OC_HIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            adet_reg  <= adet_next;
            a_par_reg <= (adet_next == 0) || (adet_next < thr_ext);
            a_seg_reg <= in_sums.seg;
            u_reg     <= flip ? -in_sums.u : in_sums.u;
            v_reg     <= flip ? -in_sums.v : in_sums.v;
            t_reg     <= flip ? -in_sums.t : in_sums.t;
        end
        if (b_ready && a_valid_reg)
        begin
            outcome_reg <= outcome_next;
            hit_reg     <= (outcome_next == rti_pkg::OC_HIT);
        end
    end

endmodule

/* rtl/ray_triangle_intersection_test.sv */
// Ray / segment versus triangle test (Moller-Trumbore), exact integer math.
// Input stream (s_*): one word per test. s_tdata carries origin, second
// vector, vertices a, b, c, 63 bits each (x,y,z signed Q11.10, x lowest);
// s_tuser is segment_mode (second vector is an endpoint, 0 < t < 1).
// Output stream (m_*): one word per test, hit in bit 0, outcome in bits 3:1
// (0 hit, 1 near parallel, 2 u outside, 3 v or u+v outside, 4 t outside).
// Config channel (cfg_*): writes det_threshold, always ready; write only
// while no test is in flight.
// Stages: differences, cross terms, cross sums, dot terms, dot sums, sign
// fix, compare. Throughput: one test per cycle while m_tready is high; each
// of the seven stages holds one word with its own valid bit.
// Stall: while m_tready is low, bubbles in the pipe are filled up before
// s_tready drops; nothing is lost or repeated.
// Reset: all stages empty, det_threshold returns to 1074 (2^-30 units).
module ray_triangle_intersection_test (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // origin[62:0], second_vector[125:63], vertex_a[188:126],
    // vertex_b[251:189], vertex_c[314:252], zero pad
    input  logic [rti_pkg::IN_TDATA_W-1:0]     s_tdata,
    // segment_mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit[0], outcome[3:1], zero pad
    output logic [rti_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rti_pkg::THR_W-1:0]          cfg_data
);

    localparam int FW = rti_pkg::FIELD_W;

    logic [rti_pkg::THR_W-1:0] thr_reg;

    logic           d_valid, d_ready;
    rti_pkg::geo_t  d_geo;
    logic           x_valid, x_ready;
    rti_pkg::xgeo_t x_geo;
    logic           s_valid, s_ready;
    rti_pkg::sums_t sums;
    logic           hit;
    logic [rti_pkg::OUTCOME_W-1:0] outcome;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rti_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    rti_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .org       (s_tdata[0*FW +: FW]),
        .sec       (s_tdata[1*FW +: FW]),
        .va        (s_tdata[2*FW +: FW]),
        .vb        (s_tdata[3*FW +: FW]),
        .vc        (s_tdata[4*FW +: FW]),
        .seg       (s_tuser),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_geo   (d_geo)
    );

    rti_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_geo    (d_geo),
        .out_valid (x_valid),
        .out_ready (x_ready),
        .out_geo   (x_geo)
    );

    rti_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .in_ready  (x_ready),
        .in_geo    (x_geo),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .out_sums  (sums)
    );

    rti_decide u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_sums       (sums),
        .det_threshold (thr_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_hit       (hit),
        .out_outcome   (outcome)
    );

    assign m_tdata = {{(rti_pkg::OUT_TDATA_W - rti_pkg::OUTCOME_W - 1){1'b0}}, outcome, hit};

endmodule

/* rtl/rti_checker.sv */
module rti_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rti_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // hit flag agrees with the outcome code
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == rti_pkg::OC_HIT)))
        else $error("hit flag disagrees with outcome");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] <= rti_pkg::OC_T_OUT))
        else $error("outcome code out of range");

    // an empty output stage means the whole pipe can take a word
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

endmodule

bind ray_triangle_intersection_test rti_checker u_rti_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
